FILE: rtl/hvn_pkg.sv
// Shared constants and types for the heightmap vertex normal block.
// No dependencies; the modules and the bench import this package, the interfaces do not.
package hvn_pkg;

  localparam int CFG_IDX_W      = 8;
  localparam int CFG_DATA_W     = 16;
  localparam int HEIGHT_W       = 8;
  localparam int SCALED_W       = 24;  // 255 * 65535 fits
  localparam int VEC_W          = SCALED_W + 1;
  localparam int FACES          = 6;
  localparam int FACE_FRAC_BITS = 28;
  localparam int SUM_COMP_W     = 32;  // six unit vectors of 2^28
  localparam int NFB_DEFAULT    = 14;
  localparam int OUT_W          = 16;
  localparam int COUNT_W        = 3;
  localparam int SQ_W           = 64;
  localparam int ROOT_W         = 32;
  localparam int SQRT_STEPS     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_CELL_DISTANCE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE  = 8'd1;
  localparam logic [CFG_DATA_W-1:0] CELL_DISTANCE_RST = 16'd256;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_SCALE_RST  = 16'd256;
  localparam logic [7:0] HEIGHT_DENOM = 8'd255;

  typedef struct packed {
    logic [HEIGHT_W-1:0] h_center;
    logic [HEIGHT_W-1:0] h_left;
    logic [HEIGHT_W-1:0] h_right;
    logic [HEIGHT_W-1:0] h_up;
    logic [HEIGHT_W-1:0] h_down;
    logic [HEIGHT_W-1:0] h_up_right;
    logic [HEIGHT_W-1:0] h_down_left;
    logic                has_left;
    logic                has_right;
    logic                has_up;
    logic                has_down;
  } vtx_t;

  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage

FILE: rtl/hvn_vtx_if.sv
// Vertex input channel: valid/ready plus raw heights and border flags.
// No dependencies; field widths are written out as literals.
interface hvn_vtx_if;
  logic       valid;
  logic       ready;
  logic [7:0] h_center;
  logic [7:0] h_left;
  logic [7:0] h_right;
  logic [7:0] h_up;
  logic [7:0] h_down;
  logic [7:0] h_up_right;
  logic [7:0] h_down_left;
  logic       has_left;
  logic       has_right;
  logic       has_up;
  logic       has_down;
  modport source (output valid, h_center, h_left, h_right, h_up, h_down, h_up_right,
                  h_down_left, has_left, has_right, has_up, has_down, input ready);
  modport sink (input valid, h_center, h_left, h_right, h_up, h_down, h_up_right,
                h_down_left, has_left, has_right, has_up, has_down, output ready);
endinterface

FILE: rtl/hvn_nrm_if.sv
// Normal output channel: valid/ready plus Q1.14 normal and face count.
// No dependencies.
interface hvn_nrm_if;
  logic        valid;
  logic        ready;
  logic [15:0] normal_x;
  logic [15:0] normal_y;
  logic [15:0] normal_z;
  logic [2:0]  face_count;
  modport source (output valid, normal_x, normal_y, normal_z, face_count, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, face_count, output ready);
endinterface

FILE: rtl/hvn_cfg_if.sv
// Configuration write channel: valid/ready, register index and data.
// No dependencies.
interface hvn_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/hvn_face.sv
// Front end: scaled heights and pitch, then the six face vectors.
// Depends on hvn_pkg. Two register stages.
module hvn_face (
  input  logic                                     clk,
  input  logic                                     rst,
  input  hvn_pkg::pipe_ctl_t                       ctl,
  input  hvn_pkg::vtx_t                            vtx,
  input  logic [15:0]                              cell_distance,
  input  logic [15:0]                              height_scale,
  output logic                                     out_valid,
  output logic [5:0][2:0][hvn_pkg::VEC_W-1:0]     vec,
  output logic [hvn_pkg::COUNT_W-1:0]             count
);
  import hvn_pkg::*;

  logic [SCALED_W-1:0] hv, hl, hr, hu, hd, hur, hdl, pitch;
  logic [FACES-1:0]    fon;
  logic [COUNT_W-1:0]  cnt1;
  logic                v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ctl.en) begin
      v1 <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      hv    <= vtx.h_center * height_scale;
      hl    <= vtx.h_left * height_scale;
      hr    <= vtx.h_right * height_scale;
      hu    <= vtx.h_up * height_scale;
      hd    <= vtx.h_down * height_scale;
      hur   <= vtx.h_up_right * height_scale;
      hdl   <= vtx.h_down_left * height_scale;
      pitch <= cell_distance * HEIGHT_DENOM;
      fon[0] <= vtx.has_right & vtx.has_down;
      fon[1] <= vtx.has_left & vtx.has_down;
      fon[2] <= vtx.has_left & vtx.has_down;
      fon[3] <= vtx.has_up & vtx.has_right;
      fon[4] <= vtx.has_up & vtx.has_right;
      fon[5] <= vtx.has_up & vtx.has_left;
      cnt1  <= COUNT_W'(vtx.has_right & vtx.has_down)
             + COUNT_W'({vtx.has_left & vtx.has_down, 1'b0})
             + COUNT_W'({vtx.has_up & vtx.has_right, 1'b0})
             + COUNT_W'(vtx.has_up & vtx.has_left);
    end
  end

  // Every face reduces to (height diff, pitch, height diff).
  logic [5:0][2:0][VEC_W-1:0] vec_next;
  logic [VEC_W-1:0] p;

  function automatic logic [VEC_W-1:0] dif(input logic [SCALED_W-1:0] a,
                                           input logic [SCALED_W-1:0] b);
    return {1'b0, a} - {1'b0, b};
  endfunction

  always_comb begin
    p = {1'b0, pitch};
    vec_next[0] = {dif(hd, hv),  p, dif(hv, hr)};
    vec_next[1] = {dif(hdl, hl), p, dif(hl, hv)};
    vec_next[2] = {dif(hd, hv),  p, dif(hdl, hd)};
    vec_next[3] = {dif(hv, hu),  p, dif(hu, hur)};
    vec_next[4] = {dif(hr, hur), p, dif(hv, hr)};
    vec_next[5] = {dif(hv, hu),  p, dif(hl, hv)};
    for (int f = 0; f < FACES; f++) begin
      if (!fon[f] || pitch == '0) begin
        vec_next[f] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      vec   <= vec_next;
      count <= cnt1;
    end
  end

endmodule

FILE: rtl/hvn_unit.sv
// Pipelined vector normaliser: squares, sum, shift search, bit-serial
// square root, restoring divide per component. Depends on hvn_pkg.
module hvn_unit #(
  parameter int IW = 25,
  parameter int FB = 28,
  parameter int TW = 3
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [2:0][IW-1:0]      in_c,
  input  logic [TW-1:0]           in_tag,
  output logic                    out_valid,
  output logic [2:0][FB+1:0]      out_c,
  output logic [TW-1:0]           out_tag
);
  import hvn_pkg::*;

  localparam int QW = FB + 1;
  localparam int NW = ROOT_W + QW;
  localparam int L  = 6 + SQRT_STEPS + 1 + QW + 1;

  // valid and tag travel alongside the data stages
  logic          vld [L];
  logic [TW-1:0] tg  [L];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < L; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < L; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tg[0] <= in_tag;
      for (int i = 1; i < L; i++) tg[i] <= tg[i-1];
    end
  end

  assign out_valid = vld[L-1];
  assign out_tag   = tg[L-1];

  logic [2:0][IW-1:0]   mag1, mag2, mag3, mag4, mag5;
  logic [2:0]           sg1, sg2, sg3, sg4, sg5;
  logic [2:0][2*IW-1:0] sq2;
  logic [SQ_W-1:0]      s3, s4, s5;
  logic [7:0]           nz4;
  logic [7:0][2:0]      gm4;
  logic [4:0]           k5;
  logic                 z5;

  function automatic logic [2:0] msb8(input logic [7:0] b);
    logic [2:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = 3'(i);
    end
    return r;
  endfunction

  logic [5:0] p;
  logic [5:0] d;
  logic       found;
  always_comb begin
    p = '0;
    found = 1'b0;
    for (int g = 0; g < 8; g++) begin
      if (nz4[g]) begin
        p = {3'(g), gm4[g]};
        found = 1'b1;
      end
    end
    d = 6'd61 - p;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sg1[k]  <= in_c[k][IW-1];
        mag1[k] <= in_c[k][IW-1] ? (~in_c[k] + 1'b1) : in_c[k];
        sq2[k]  <= {{IW{1'b0}}, mag1[k]} * {{IW{1'b0}}, mag1[k]};
      end
      mag2 <= mag1;  sg2 <= sg1;
      s3   <= SQ_W'(sq2[0]) + SQ_W'(sq2[1]) + SQ_W'(sq2[2]);
      mag3 <= mag2;  sg3 <= sg2;
      for (int g = 0; g < 8; g++) begin
        nz4[g] <= |s3[8*g +: 8];
        gm4[g] <= msb8(s3[8*g +: 8]);
      end
      s4 <= s3;  mag4 <= mag3;  sg4 <= sg3;
      // least k with s * 4^k >= 2^60
      k5 <= (p >= 6'd60) ? 5'd0 : d[5:1];
      z5 <= !found;
      s5 <= s4;  mag5 <= mag4;  sg5 <= sg4;
    end
  end

  logic [SQ_W-1:0]          sv  [SQRT_STEPS+1];
  logic [SQ_W-1:0]          sr  [SQRT_STEPS+1];
  logic [2:0][ROOT_W-1:0]   sm  [SQRT_STEPS+1];
  logic [2:0]               ssg [SQRT_STEPS+1];
  logic                     sz  [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sv[0] <= s5 << {k5, 1'b0};
      sr[0] <= '0;
      for (int k = 0; k < 3; k++) sm[0][k] <= ROOT_W'(mag5[k]) << k5;
      ssg[0] <= sg5;
      sz[0]  <= z5;
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2*SQRT_STEPS - 2 - 2*j);
    logic [SQ_W:0] t;
    logic          take;
    always_comb begin
      t    = {1'b0, sr[j]} + {1'b0, BIT};
      take = ({1'b0, sv[j]} >= t);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sv[j+1]  <= take ? sv[j] - t[SQ_W-1:0] : sv[j];
        sr[j+1]  <= take ? (sr[j] >> 1) + BIT : sr[j] >> 1;
        sm[j+1]  <= sm[j];
        ssg[j+1] <= ssg[j];
        sz[j+1]  <= sz[j];
      end
    end
  end

  logic [ROOT_W-1:0]       len;
  logic [2:0][NW-1:0]      num;
  assign len = sr[SQRT_STEPS][ROOT_W-1:0];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[k] = {1'b0, sm[SQRT_STEPS][k], {FB{1'b0}}} + NW'(len >> 1);
    end
  end

  logic [2:0][ROOT_W-1:0] dr   [QW+1];
  logic [2:0][QW-1:0]     dlo  [QW+1];
  logic [2:0][QW-1:0]     dq   [QW+1];
  logic [ROOT_W-1:0]      dlen [QW+1];
  logic [2:0]             dsg  [QW+1];
  logic                   dz   [QW+1];

  // quotient fits QW bits, so the top of the numerator is already below len
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dr[0][k]  <= num[k][NW-1:QW];
        dlo[0][k] <= num[k][QW-1:0];
      end
      dq[0]   <= '0;
      dlen[0] <= len;
      dsg[0]  <= ssg[SQRT_STEPS];
      dz[0]   <= sz[SQRT_STEPS];
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    logic [2:0][ROOT_W:0] t;
    logic [2:0]           qb;
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        t[k]  = {dr[i][k], dlo[i][k][QW-1]};
        qb[k] = (t[k] >= {1'b0, dlen[i]});
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          dr[i+1][k]  <= qb[k] ? ROOT_W'(t[k] - {1'b0, dlen[i]}) : t[k][ROOT_W-1:0];
          dlo[i+1][k] <= dlo[i][k] << 1;
          dq[i+1][k]  <= {dq[i][k][QW-2:0], qb[k]};
        end
        dlen[i+1] <= dlen[i];
        dsg[i+1]  <= dsg[i];
        dz[i+1]   <= dz[i];
      end
    end
  end

  localparam logic [QW-1:0] LIM = QW'(1) << FB;
  logic [2:0][QW-1:0] qc;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qc[k] = (dq[QW][k] > LIM) ? LIM : dq[QW][k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (dz[QW]) out_c[k] <= '0;
        else if (dsg[QW][k]) out_c[k] <= -{1'b0, qc[k]};
        else out_c[k] <= {1'b0, qc[k]};
      end
    end
  end

endmodule

FILE: rtl/heightmap_vertex_normal.sv
// Top level: config registers, face front end, six face normalisers,
// face sum and final normaliser. Depends on hvn_pkg, interfaces, units.
//
//   channel  dir  handshake    beat contents
//   vtx      in   valid/ready  seven heights, four border flags
//   nrm      out  valid/ready  normal_x/y/z (Q1.NFB), face_count
//   cfg      in   valid/ready  index, data (ready always high)
//
// One vertex per cycle sustained while the output is taken; the depth is
// set by the 32-step root and the per-bit dividers.
// rst is synchronous and clears only valid bits and config registers.
// The whole pipeline moves on one enable; it holds while a result sits
// in the output register untaken, losing and repeating nothing.
module heightmap_vertex_normal #(
  parameter int NORMAL_FRAC_BITS = hvn_pkg::NFB_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  hvn_vtx_if.sink  vtx,
  hvn_nrm_if.source nrm,
  hvn_cfg_if.sink  cfg
);
  import hvn_pkg::*;

  localparam int FW = FACE_FRAC_BITS + 2;
  localparam int NW = NORMAL_FRAC_BITS + 2;

  logic [15:0] cell_distance, height_scale;
  logic        en;
  pipe_ctl_t   ctl;
  vtx_t        vin;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_distance <= CELL_DISTANCE_RST;
      height_scale  <= HEIGHT_SCALE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_CELL_DISTANCE: cell_distance <= cfg.data;
        CFG_HEIGHT_SCALE:  height_scale  <= cfg.data;
        default: ;
      endcase
    end
  end

  assign en        = !nrm.valid || nrm.ready;
  assign vtx.ready = en;
  assign ctl       = '{en: en, valid: vtx.valid};

  assign vin = '{h_center: vtx.h_center, h_left: vtx.h_left, h_right: vtx.h_right,
                 h_up: vtx.h_up, h_down: vtx.h_down, h_up_right: vtx.h_up_right,
                 h_down_left: vtx.h_down_left, has_left: vtx.has_left,
                 has_right: vtx.has_right, has_up: vtx.has_up, has_down: vtx.has_down};

  logic                      fv;
  logic [5:0][2:0][VEC_W-1:0] vec;
  logic [COUNT_W-1:0]        fcount;

  hvn_face u_face (
    .clk, .rst, .ctl, .vtx(vin), .cell_distance, .height_scale,
    .out_valid(fv), .vec, .count(fcount)
  );

  logic [5:0][2:0][FW-1:0] fq;
  logic                    uv;
  logic [COUNT_W-1:0]      ucount;

  hvn_unit #(.IW(VEC_W), .FB(FACE_FRAC_BITS), .TW(COUNT_W)) u_f0 (
    .clk, .rst, .en, .in_valid(fv), .in_c(vec[0]), .in_tag(fcount),
    .out_valid(uv), .out_c(fq[0]), .out_tag(ucount)
  );

  for (genvar f = 1; f < FACES; f++) begin : g_face
    hvn_unit #(.IW(VEC_W), .FB(FACE_FRAC_BITS), .TW(COUNT_W)) u_fn (
      .clk, .rst, .en, .in_valid(fv), .in_c(vec[f]), .in_tag(fcount),
      .out_valid(), .out_c(fq[f]), .out_tag()
    );
  end

  logic [2:0][SUM_COMP_W-1:0] acc, acc_next;
  logic                       av;
  logic [COUNT_W-1:0]         acount;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc_next[k] = '0;
      for (int f = 0; f < FACES; f++) begin
        acc_next[k] = acc_next[k] + SUM_COMP_W'(signed'(fq[f][k]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      av <= 1'b0;
    end else if (en) begin
      av <= uv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc    <= acc_next;
      acount <= ucount;
    end
  end

  logic [2:0][NW-1:0]  nq;
  logic                nv;
  logic [COUNT_W-1:0]  ncount;

  hvn_unit #(.IW(SUM_COMP_W), .FB(NORMAL_FRAC_BITS), .TW(COUNT_W)) u_sum (
    .clk, .rst, .en, .in_valid(av), .in_c(acc), .in_tag(acount),
    .out_valid(nv), .out_c(nq), .out_tag(ncount)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      nrm.valid <= 1'b0;
    end else if (en) begin
      nrm.valid <= nv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrm.normal_x   <= OUT_W'(signed'(nq[0]));
      nrm.normal_y   <= OUT_W'(signed'(nq[1]));
      nrm.normal_z   <= OUT_W'(signed'(nq[2]));
      nrm.face_count <= ncount;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    nrm.valid |-> nrm.face_count <= 3'd6)
    else $error("face count above six");

  a_no_face_zero: assert property (@(posedge clk) disable iff (rst)
    nrm.valid && nrm.face_count == 3'd0 |->
      nrm.normal_x == 16'd0 && nrm.normal_y == 16'd0 && nrm.normal_z == 16'd0)
    else $error("normal without any face");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !nrm.valid)
    else $error("result present straight after reset");

endmodule

FILE: tb/sv/hvn_normal_checker.sv
`timescale 1ns / 100ps
// Checker for heightmap_vertex_normal: tracks the config registers, predicts
// the smoothed vertex normal of every vertex beat and compares output beats.
// Depends on hvn_pkg and the vtx/nrm/cfg channel interfaces.
module hvn_normal_checker #(
  parameter int NORMAL_FRAC_BITS = hvn_pkg::NFB_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  hvn_vtx_if   vtx,
  hvn_nrm_if   nrm,
  hvn_cfg_if   cfg,
  output int   fail_count,
  output int   pending
);
  import hvn_pkg::*;

  localparam int TRI_FRAC = 28;

  typedef longint vec3_t [3];
  typedef struct {
    logic [OUT_W-1:0]   nx;
    logic [OUT_W-1:0]   ny;
    logic [OUT_W-1:0]   nz;
    logic [COUNT_W-1:0] faces;
  } normal_t;

  normal_t     normal_q[$];
  logic [15:0] pitch_reg;
  logic [15:0] scale_reg;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned absv(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // scale up until the squared length reaches 2^60, then divide by the root
  function automatic void unit_vec(input vec3_t vin, input int fbits, output vec3_t vout);
    vec3_t           c;
    longint unsigned sq, len, lim, m, q;
    sq = 0;
    for (int k = 0; k < 3; k++) begin
      c[k] = vin[k];
      sq += absv(c[k]) * absv(c[k]);
    end
    if (sq == 0) begin
      vout = '{0, 0, 0};
      return;
    end
    while (sq < (64'd1 << 60)) begin
      for (int k = 0; k < 3; k++) c[k] = c[k] * 2;
      sq = sq * 4;
    end
    len = root_floor(sq);
    lim = 64'd1 << fbits;
    for (int k = 0; k < 3; k++) begin
      m = absv(c[k]);
      q = ((m << fbits) + (len >> 1)) / len;
      if (q > lim) q = lim;
      vout[k] = (c[k] < 0) ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic void add_tri(input int c0, r0, c1, r1, c2, r2,
                                  input longint h0, h1, h2, pitch,
                                  inout vec3_t acc);
    longint u0, w0, y0, u1, w1, y1;
    vec3_t  v, n;
    u0 = c1 - c0; w0 = -(r1 - r0); y0 = h1 - h0;
    u1 = c2 - c0; w1 = -(r2 - r0); y1 = h2 - h0;
    if (pitch == 0) return;
    v[0] = y0 * w1 - w0 * y1;
    v[1] = pitch * (w0 * u1 - u0 * w1);
    v[2] = u0 * y1 - y0 * u1;
    unit_vec(v, TRI_FRAC, n);
    for (int k = 0; k < 3; k++) acc[k] += n[k];
  endfunction

  function automatic normal_t vertex_normal(vtx_t v);
    longint  hs, hc, hl, hr, hu, hd, hur, hdl, pitch;
    vec3_t   acc, n;
    normal_t res;
    int      cnt;
    hs = scale_reg;
    hc = v.h_center * hs;  hl = v.h_left * hs;  hr = v.h_right * hs;
    hu = v.h_up * hs;      hd = v.h_down * hs;
    hur = v.h_up_right * hs;  hdl = v.h_down_left * hs;
    pitch = 255 * longint'(pitch_reg);
    acc = '{0, 0, 0};
    cnt = 0;
    if (v.has_right && v.has_down) begin
      add_tri(0, 0, 1, 0, 0, 1, hc, hr, hd, pitch, acc);
      cnt += 1;
    end
    if (v.has_left && v.has_down) begin
      add_tri(-1, 0, 0, 0, -1, 1, hl, hc, hdl, pitch, acc);
      add_tri(-1, 1, 0, 0, 0, 1, hdl, hc, hd, pitch, acc);
      cnt += 2;
    end
    if (v.has_up && v.has_right) begin
      add_tri(0, -1, 1, -1, 0, 0, hu, hur, hc, pitch, acc);
      add_tri(0, 0, 1, -1, 1, 0, hc, hur, hr, pitch, acc);
      cnt += 2;
    end
    if (v.has_up && v.has_left) begin
      add_tri(-1, 0, 0, -1, 0, 0, hl, hu, hc, pitch, acc);
      cnt += 1;
    end
    unit_vec(acc, NORMAL_FRAC_BITS, n);
    res.nx = n[0][15:0];
    res.ny = n[1][15:0];
    res.nz = n[2][15:0];
    res.faces = cnt[2:0];
    return res;
  endfunction

  always @(posedge clk) begin
    vtx_t    v;
    normal_t e;
    if (rst) begin
      pitch_reg = CELL_DISTANCE_RST;
      scale_reg = HEIGHT_SCALE_RST;
      normal_q.delete();
      fail_count = 0;
    end else begin
      // output beat first: a vertex accepted this edge cannot already be out
      if (nrm.valid && nrm.ready) begin
        if (normal_q.size() == 0) begin
          $error("normal beat with nothing expected");
          fail_count++;
        end else begin
          e = normal_q.pop_front();
          if (nrm.normal_x !== e.nx) begin
            $error("normal_x expected %0d got %0d", $signed(e.nx), $signed(nrm.normal_x));
            fail_count++;
          end
          if (nrm.normal_y !== e.ny) begin
            $error("normal_y expected %0d got %0d", $signed(e.ny), $signed(nrm.normal_y));
            fail_count++;
          end
          if (nrm.normal_z !== e.nz) begin
            $error("normal_z expected %0d got %0d", $signed(e.nz), $signed(nrm.normal_z));
            fail_count++;
          end
          if (nrm.face_count !== e.faces) begin
            $error("face_count expected %0d got %0d", e.faces, nrm.face_count);
            fail_count++;
          end
        end
      end
      if (vtx.valid && vtx.ready) begin
        v = '{vtx.h_center, vtx.h_left, vtx.h_right, vtx.h_up, vtx.h_down,
              vtx.h_up_right, vtx.h_down_left, vtx.has_left, vtx.has_right,
              vtx.has_up, vtx.has_down};
        normal_q = {normal_q, vertex_normal(v)};
      end
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_CELL_DISTANCE) pitch_reg = cfg.data;
        else if (cfg.index == CFG_HEIGHT_SCALE) scale_reg = cfg.data;
      end
    end
    pending = normal_q.size();
  end
endmodule

FILE: tb/sv/heightmap_vertex_normal_tb.sv
`timescale 1ns / 100ps
// Top of the heightmap_vertex_normal bench: clock, reset, vertex and config
// stimulus, output back-pressure and the verdict. Depends on hvn_pkg, the
// channel interfaces and hvn_normal_checker.
module heightmap_vertex_normal_tb;
  import hvn_pkg::*;

  localparam int DRAIN_CYCLES = 200;   // longer than the pipeline latency at the default width
  localparam int IDLE_LIMIT   = 5000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  logic out_steady;   // stretch with no output stalls

  hvn_vtx_if vtx ();
  hvn_nrm_if nrm ();
  hvn_cfg_if cfg ();

  heightmap_vertex_normal u_dut (.clk(clk), .rst(rst), .vtx(vtx), .nrm(nrm), .cfg(cfg));

  hvn_normal_checker u_chk (
    .clk(clk), .rst(rst), .vtx(vtx), .nrm(nrm), .cfg(cfg),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_height(logic [7:0] base);
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2, 3, 4: return base + 8'($urandom_range(0, 8)) - 8'd4;  // gentle slope
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic vtx_t random_vertex();
    vtx_t       v;
    logic [7:0] base;
    base = 8'($urandom);
    v.h_center    = pick_height(base);
    v.h_left      = pick_height(base);
    v.h_right     = pick_height(base);
    v.h_up        = pick_height(base);
    v.h_down      = pick_height(base);
    v.h_up_right  = pick_height(base);
    v.h_down_left = pick_height(base);
    // interior vertices most of the time, borders the rest
    if ($urandom_range(0, 3) != 0) {v.has_left, v.has_right, v.has_up, v.has_down} = 4'hF;
    else {v.has_left, v.has_right, v.has_up, v.has_down} = 4'($urandom);
    return v;
  endfunction

  task automatic send_vertex(vtx_t v);
    int g;
    {vtx.h_center, vtx.h_left, vtx.h_right, vtx.h_up, vtx.h_down, vtx.h_up_right,
     vtx.h_down_left, vtx.has_left, vtx.has_right, vtx.has_up, vtx.has_down} = v;
    vtx.valid = 1'b1;
    do @(posedge clk); while (!vtx.ready);
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      vtx.valid = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    cfg.index = idx;
    cfg.data  = val;
    cfg.valid = 1'b1;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // block drained before touching the registers
  task automatic settle();
    vtx.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // output back-pressure
  initial begin
    int g;
    nrm.ready  = 1'b0;
    out_steady = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) out_steady = ~out_steady;
      if (out_steady) begin
        nrm.ready = 1'b1;
      end else begin
        g = gap_len();
        if (g > 0) begin
          nrm.ready = 1'b0;
          repeat (g - 1) @(negedge clk);
        end else begin
          nrm.ready = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (vtx.valid && vtx.ready) || (nrm.valid && nrm.ready) ||
        (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    vtx_t        v;
    logic [15:0] pitch_set [6];
    logic [15:0] scale_set [6];
    rst = 1'b1;
    {vtx.h_center, vtx.h_left, vtx.h_right, vtx.h_up, vtx.h_down, vtx.h_up_right,
     vtx.h_down_left, vtx.has_left, vtx.has_right, vtx.has_up, vtx.has_down} = '0;
    vtx.valid = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_CELL_DISTANCE;
    cfg.data  = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // directed: every border combination, flat, peak, pit and extremes
    for (int f = 0; f < 16; f++) begin
      v = '{8'd128, 8'd64, 8'd200, 8'd10, 8'd250, 8'd0, 8'd255, f[3], f[2], f[1], f[0]};
      send_vertex(v);
    end
    send_vertex('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1});
    send_vertex('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                  1'b1, 1'b1, 1'b1, 1'b1});
    send_vertex('{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1});
    send_vertex('{8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                  1'b1, 1'b1, 1'b1, 1'b1});
    send_vertex('{8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b1, 1'b1, 1'b1, 1'b1});
    for (int i = 0; i < 250; i++) send_vertex(random_vertex());

    // register settings, extremes first; zero pitch makes every face degenerate
    pitch_set = '{16'd1, 16'd65535, 16'd1, 16'd65535, 16'd0, 16'd0};
    scale_set = '{16'd0, 16'd65535, 16'd65535, 16'd1, 16'd256, 16'd0};
    for (int p = 0; p < 6; p++) begin
      settle();
      if (p == 5) begin
        pitch_set[p] = 16'($urandom_range(1, 65535));
        scale_set[p] = 16'($urandom);
      end
      // unknown indexes are ignored by the block
      if (p == 2) write_reg(8'hFF, 16'hFFFF);
      if (p == 3) write_reg(8'($urandom_range(2, 255)), 16'($urandom));
      write_reg(CFG_CELL_DISTANCE, pitch_set[p]);
      write_reg(CFG_HEIGHT_SCALE, scale_set[p]);
      for (int i = 0; i < 240; i++) send_vertex(random_vertex());
    end

    vtx.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
